// File: hw/rtl/cbcd_pkg.sv
package cbcd_pkg;

  // Compass code of the result. Up is +y, right is +x.
  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_NONE  = 3'd4
  } dir_t;

  // One ball and box pair, all in 1/16 pixel.
  typedef struct packed {
    logic signed [15:0] ball_x;
    logic signed [15:0] ball_y;
    logic        [14:0] ball_diameter;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic        [14:0] box_width;
    logic        [14:0] box_height;
  } pair_t;

  // One test result, offsets in 1/32 pixel.
  typedef struct packed {
    logic               hit;
    logic        [2:0]  direction;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
  } result_t;

  // Widths of the internal 1/32 pixel arithmetic.
  localparam int unsigned AxisW = 19;
  localparam int unsigned SqW   = 2 * AxisW;
  localparam int unsigned RadW  = 30;

endpackage

// File: hw/rtl/cbcd_if.sv
interface cbcd_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/circle_box_collision_direction.sv
// Circle versus axis-aligned box collision test. Each transfer on req carries a
// ball (bounding corner and diameter) and a box (corner, width, height) in
// 1/16 pixel; each one yields exactly one transfer on rsp with a hit flag, a
// compass direction and the offset from the ball centre to the closest box
// point in 1/32 pixel. On a miss the direction is up and both offsets are
// zero; on a hit with zero offset the direction code is four. The block is a
// four stage pipeline (centre difference, clamp, squares and direction pick,
// sum and compare into the output register), so it takes one pair per clock
// while rsp does not stall. A result passes through the stage 1, 2 and 3
// registers and the output register before it shows on rsp. The squaring
// multipliers are 19 by 19 bits and the compare is a 39 bit add and compare.
// Each stage advances when the stage after it is empty or moving, so a stall
// on rsp fills bubbles first and only then drops req.ready.
module circle_box_collision_direction (
  input logic   clk,
  input logic   rst,
  cbcd_if.sink   req,
  cbcd_if.source rsp
);
  import cbcd_pkg::*;

  // Stage 1: centre difference per axis, centre minus box centre.
  logic                    v1;
  logic signed [AxisW-1:0] diff_x;
  logic signed [AxisW-1:0] diff_y;
  logic        [14:0]      size_x1;
  logic        [14:0]      size_y1;
  logic        [14:0]      diam1;

  // Stage 2: offset of the closest box point from the ball centre.
  logic                    v2;
  logic signed [AxisW-1:0] off_x;
  logic signed [AxisW-1:0] off_y;
  logic        [14:0]      diam2;

  // Stage 3: squares and the direction pick.
  logic               v3;
  logic [SqW-1:0]     sq_x;
  logic [SqW-1:0]     sq_y;
  logic [RadW-1:0]    rad2;
  logic signed [15:0] off_x3;
  logic signed [15:0] off_y3;
  dir_t               dir3;

  // Output register.
  logic    out_valid;
  result_t out_data;

  // Advance enables, from the output back to the input.
  logic en_out;
  logic en3;
  logic en2;
  logic en1;

  assign en_out    = !out_valid || rsp.ready;
  assign en3       = !v3 || en_out;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req.ready = en1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // Stage 1 logic. The centres are 2*corner + size in 1/32 pixel; the
  // difference stays well inside 19 signed bits.
  logic signed [AxisW-1:0] diff_x_next;
  logic signed [AxisW-1:0] diff_y_next;

  always_comb begin
    logic signed [AxisW-1:0] ball_cx, ball_cy, box_cx, box_cy;
    // Sign extension of the doubled corners.
    ball_cx = AxisW'(signed'({{2{req.data.ball_x[15]}}, req.data.ball_x, 1'b0}))
              + AxisW'({1'b0, req.data.ball_diameter});
    ball_cy = AxisW'(signed'({{2{req.data.ball_y[15]}}, req.data.ball_y, 1'b0}))
              + AxisW'({1'b0, req.data.ball_diameter});
    box_cx  = AxisW'(signed'({{2{req.data.box_x[15]}}, req.data.box_x, 1'b0}))
              + AxisW'({1'b0, req.data.box_width});
    box_cy  = AxisW'(signed'({{2{req.data.box_y[15]}}, req.data.box_y, 1'b0}))
              + AxisW'({1'b0, req.data.box_height});
    diff_x_next = ball_cx - box_cx;
    diff_y_next = ball_cy - box_cy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid;
    end
    if (en1 && req.valid) begin
      diff_x  <= diff_x_next;
      diff_y  <= diff_y_next;
      size_x1 <= req.data.box_width;
      size_y1 <= req.data.box_height;
      diam1   <= req.data.ball_diameter;
    end
  end

  // Stage 2 logic. The closest point minus the ball centre equals the
  // clamped difference minus the difference, so it is zero inside the box.
  logic signed [AxisW-1:0] off_x_next;
  logic signed [AxisW-1:0] off_y_next;

  always_comb begin
    logic signed [AxisW-1:0] half_x, half_y;
    half_x = AxisW'({1'b0, size_x1});
    half_y = AxisW'({1'b0, size_y1});
    if (diff_x < -half_x) begin
      off_x_next = -half_x - diff_x;
    end else if (diff_x > half_x) begin
      off_x_next = half_x - diff_x;
    end else begin
      off_x_next = '0;
    end
    if (diff_y < -half_y) begin
      off_y_next = -half_y - diff_y;
    end else if (diff_y > half_y) begin
      off_y_next = half_y - diff_y;
    end else begin
      off_y_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      off_x <= off_x_next;
      off_y <= off_y_next;
      diam2 <= diam1;
    end
  end

  // Stage 3 logic. Candidates are taken in the order up, right, down, left;
  // one wins only by strictly beating zero and every earlier winner.
  logic signed [SqW-1:0] sq_x_next;
  logic signed [SqW-1:0] sq_y_next;
  dir_t                  dir_next;

  assign sq_x_next = off_x * off_x;
  assign sq_y_next = off_y * off_y;

  always_comb begin
    logic signed [AxisW:0] c_up, c_right, c_down, c_left, best;
    c_up    = (AxisW+1)'(off_y);
    c_right = (AxisW+1)'(off_x);
    c_down  = -c_up;
    c_left  = -c_right;
    best     = '0;
    dir_next = DIR_NONE;
    if (c_up > best) begin
      best     = c_up;
      dir_next = DIR_UP;
    end
    if (c_right > best) begin
      best     = c_right;
      dir_next = DIR_RIGHT;
    end
    if (c_down > best) begin
      best     = c_down;
      dir_next = DIR_DOWN;
    end
    if (c_left > best) begin
      dir_next = DIR_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3 && v2) begin
      sq_x   <= SqW'(unsigned'(sq_x_next));
      sq_y   <= SqW'(unsigned'(sq_y_next));
      rad2   <= {15'd0, diam2} * {15'd0, diam2};
      off_x3 <= off_x[15:0];
      off_y3 <= off_y[15:0];
      dir3   <= dir_next;
    end
  end

  // Stage 4 logic: squared distance against squared radius. On a hit each
  // offset magnitude is below the diameter, so 16 bits hold it exactly.
  logic [SqW:0] dist2;
  logic         hit_next;
  result_t      out_next;

  assign dist2    = {1'b0, sq_x} + {1'b0, sq_y};
  assign hit_next = dist2 < (SqW+1)'(rad2);

  always_comb begin
    out_next.hit = hit_next;
    if (hit_next) begin
      out_next.direction = dir3;
      out_next.offset_x  = off_x3;
      out_next.offset_y  = off_y3;
    end else begin
      out_next.direction = DIR_UP;
      out_next.offset_x  = '0;
      out_next.offset_y  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= v3;
    end
    if (en_out && v3) begin
      out_data <= out_next;
    end
  end

  // A miss always reports up with zero offsets.
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |->
      (out_data.direction == DIR_UP && out_data.offset_x == 16'sd0 &&
       out_data.offset_y == 16'sd0))
    else $error("miss result carries direction or offset");

  // Direction code four only for a zero offset.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit && out_data.direction == DIR_NONE) |->
      (out_data.offset_x == 16'sd0 && out_data.offset_y == 16'sd0))
    else $error("zero-offset direction with nonzero offset");

  // An up result needs a positive y offset.
  a_up_positive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit && out_data.direction == DIR_UP) |->
      (out_data.offset_y > 16'sd0))
    else $error("up direction without positive y offset");

  // With every stage full and the output stalled, no request is taken.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && out_valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while the pipeline is full and stalled");

  // A filled stage moves on whenever the output drains.
  a_drain_moves: assert property (@(posedge clk) disable iff (rst)
    (v3 && rsp.ready) |=> out_valid)
    else $error("stage three item lost while the output drained");

endmodule

// File: bench/circle_box_collision_direction_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the circle versus box collision block.
// Pairs go in on the req channel and results come back on rsp, one per pair.
// A predictor in this file, or the directed table, gives each expected result,
// which is queued when its pair is accepted. The monitor compares every returned
// result, field by field, with the oldest expected one.
module circle_box_collision_direction_test;
  import cbcd_pkg::*;

  // The block is a four stage pipeline, so a few extra cycles at the end are
  // enough to catch a stray result. The cycle limit is far above any correct run.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_PAIRS = 400;

  // After this many accepted pairs the receiver stops taking results for a long
  // stretch. The sender keeps offering pairs, so the pipeline fills and req
  // backs up.
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_CYCLES = 120;

  localparam result_t NO_CONTACT = '{hit: 1'b0, direction: DIR_UP, offset_x: '0, offset_y: '0};
  localparam result_t CENTRED    = '{hit: 1'b1, direction: DIR_NONE, offset_x: '0, offset_y: '0};

  // The receiver cycles through these stall patterns in turn.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CADENCE,
    RX_SPARSE
  } rx_mode_t;

  // One row of the directed table. Where known is set, the result is typed in
  // by hand. Otherwise the predictor supplies it.
  typedef struct {
    pair_t   pair;
    bit      known;
    result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbcd_if #(.payload_t(pair_t))   req_ch ();
  cbcd_if #(.payload_t(result_t)) rsp_ch ();

  circle_box_collision_direction u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  result_t       expected_results[$];
  directed_row_t directed_rows[$];

  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned contact_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned input_held_cycles = 0;
  int unsigned dir_seen[8];
  int unsigned burst_left = 0;

  logic [31:0] rx_cycle = '0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // All arithmetic is done in 1/32 pixel, so the ball centre is twice the
  // corner plus the diameter. The box centre is twice the corner plus the size,
  // and the half extent in these units is simply the size. The function
  // returns the closest box point minus the ball centre along one axis.
  function automatic int nearest_gap(int corner, int diam, int box_corner, int extent);
    int centre;
    int box_centre;
    int diff;
    int clamped;
    centre     = 2 * corner + diam;
    box_centre = 2 * box_corner + extent;
    diff       = centre - box_centre;
    if (diff < -extent) begin
      clamped = -extent;
    end else if (diff > extent) begin
      clamped = extent;
    end else begin
      clamped = diff;
    end
    return box_centre + clamped - centre;
  endfunction

  // The candidates are taken as up, right, down, left. A candidate replaces the
  // current pick only when it is strictly larger than zero and than the pick so
  // far, so ties keep the earlier direction. A zero offset yields DIR_NONE.
  function automatic dir_t compass_of(int gap_x, int gap_y);
    int   cand[4];
    dir_t order[4];
    int   best_val;
    dir_t best;
    cand[0]  = gap_y;
    cand[1]  = gap_x;
    cand[2]  = -gap_y;
    cand[3]  = -gap_x;
    order[0] = DIR_UP;
    order[1] = DIR_RIGHT;
    order[2] = DIR_DOWN;
    order[3] = DIR_LEFT;
    best_val = 0;
    best     = DIR_NONE;
    for (int i = 0; i < 4; i++) begin
      if (cand[i] > best_val) begin
        best_val = cand[i];
        best     = order[i];
      end
    end
    return best;
  endfunction

  // A contact requires the squared distance to be strictly below the squared
  // diameter, which is the squared radius in 1/32 pixel units. A zero
  // diameter therefore never makes contact.
  function automatic result_t predict_contact(pair_t p);
    int      gap_x;
    int      gap_y;
    longint  dist2;
    longint  rad2;
    result_t r;
    gap_x = nearest_gap(p.ball_x, p.ball_diameter, p.box_x, p.box_width);
    gap_y = nearest_gap(p.ball_y, p.ball_diameter, p.box_y, p.box_height);
    dist2 = longint'(gap_x) * gap_x + longint'(gap_y) * gap_y;
    rad2  = longint'(p.ball_diameter) * p.ball_diameter;
    r     = NO_CONTACT;
    if (dist2 < rad2) begin
      r.hit       = 1'b1;
      r.direction = compass_of(gap_x, gap_y);
      r.offset_x  = 16'(gap_x);
      r.offset_y  = 16'(gap_y);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pair_t make_pair(int bx, int by, int d, int qx, int qy, int w, int h);
    pair_t p;
    p.ball_x        = 16'(bx);
    p.ball_y        = 16'(by);
    p.ball_diameter = 15'(d);
    p.box_x         = 16'(qx);
    p.box_y         = 16'(qy);
    p.box_width     = 15'(w);
    p.box_height    = 15'(h);
    return p;
  endfunction

  function automatic void add_row(pair_t p, bit known, result_t want);
    directed_row_t row;
    row.pair  = p;
    row.known = known;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Sizes are mostly small so that contacts are common. Now and then a size
  // spans the full 15 bits, so every bit of the field sees both values.
  function automatic int pick_extent();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return 0;
    end else if (roll < 3) begin
      return $urandom_range(0, 32767);
    end
    return $urandom_range(1, 300);
  endfunction

  // Most random pairs place the ball near the box, which exercises the clamp,
  // the compare and every direction. Some pairs are centred or just touching,
  // and the remainder are plain noise over the full field ranges.
  function automatic pair_t random_pair();
    int    kind;
    int    d;
    int    w;
    int    h;
    int    qx;
    int    qy;
    int    k;
    int    m;
    pair_t p;
    kind = $urandom_range(0, 9);
    d    = pick_extent();
    w    = pick_extent();
    h    = pick_extent();
    qx   = int'($urandom_range(0, 65535)) - 32768;
    qy   = int'($urandom_range(0, 65535)) - 32768;
    if (kind < 2) begin
      p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 8) begin
      // The ball overlaps the box span on each axis, with a small margin.
      p = make_pair(qx + int'($urandom_range(0, w + d + 8)) - d - 4,
                    qy + int'($urandom_range(0, h + d + 8)) - d - 4,
                    d, qx, qy, w, h);
    end else if (kind == 8) begin
      // The ball rests against the right edge of the box, exactly tangent.
      p = make_pair(qx + w, qy + int'($urandom_range(0, h)), d, qx, qy, w, h);
    end else begin
      // Ball and box share a centre, so the offset is zero on both axes.
      k = $urandom_range(0, 200);
      m = $urandom_range(0, 200);
      d = $urandom_range(0, 32767 - 2 * 200);
      p = make_pair(qx + k, qy + m, d, qx, qy, d + 2 * k, d + 2 * m);
    end
    return p;
  endfunction

  // Offers one pair and waits for the transfer. The expected result is queued
  // at the same rising edge where the block accepts the pair.
  task automatic offer_pair(input pair_t p, input result_t want);
    req_ch.valid <= 1'b1;
    req_ch.data  <= p;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    expected_results.push_back(want);
    accepted_count++;
    @(negedge clk);
  endtask

  // The sender works in bursts. Between bursts it drops valid for a random
  // gap, but a quarter of the gaps are empty, so bursts often run together.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic compare_field(input string field, input logic signed [16:0] want,
                               input logic signed [16:0] got);
    if (got !== want) begin
      $error("Field %s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver drives ready at the falling edge. Its stall pattern steps
  // through the modes in turn, so stalls land on every phase of the pipeline. One long
  // hold-off happens partway through the random part.
  always @(negedge clk) begin : drain_results
    rx_mode_t mode;
    if (!rst) begin
      rx_cycle <= rx_cycle + 1;
      mode = rx_mode_t'(rx_cycle[7:6]);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES - 1;
        hold_done    <= 1'b1;
      end else begin
        case (mode)
          RX_OPEN:    rsp_ch.ready <= 1'b1;
          RX_COIN:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_CADENCE: rsp_ch.ready <= (rx_cycle % 3 != 0);
          default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Every result transfer is checked against the oldest expected result. The
  // monitor also counts cycles where the block refused an offered pair, which
  // shows that the long hold-off really backed up the input.
  always @(posedge clk) begin : score_results
    result_t want;
    if (!rst && req_ch.valid && !req_ch.ready) begin
      input_held_cycles++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("Result with no pair outstanding: hit %0b direction %0d",
               rsp_ch.data.hit, rsp_ch.data.direction);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("hit", want.hit, rsp_ch.data.hit);
        compare_field("direction", want.direction, rsp_ch.data.direction);
        compare_field("offset_x", want.offset_x, rsp_ch.data.offset_x);
        compare_field("offset_y", want.offset_y, rsp_ch.data.offset_y);
        if (rsp_ch.data.hit === 1'b1) begin
          contact_count++;
        end
        if (!$isunknown(rsp_ch.data.direction)) begin
          dir_seen[rsp_ch.data.direction]++;
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk) begin : watchdog
    int unsigned cycle_count;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("Run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    result_t want;
    pair_t   rand_pair;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;

    // The directed table. Rows with a typed result are the obvious ones: zero
    // diameter, far apart, exactly tangent, and ball and box sharing a centre.
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0), 1'b1, NO_CONTACT);
    // A zero diameter ball inside a huge box still misses.
    add_row(make_pair(0, 0, 0, -100, -100, 32767, 32767), 1'b1, NO_CONTACT);
    add_row(make_pair(0, 0, 32, 0, 0, 32, 32), 1'b1, CENTRED);
    add_row(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1, CENTRED);
    add_row(make_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767), 1'b1, CENTRED);
    add_row(make_pair(-32768, -32768, 32767, 32767, 32767, 0, 0), 1'b1, NO_CONTACT);
    add_row(make_pair(32767, 32767, 32767, -32768, -32768, 32767, 32767), 1'b1, NO_CONTACT);
    // The distance equals the radius, which does not count as contact.
    add_row(make_pair(0, 0, 64, 64, 0, 0, 64), 1'b1, NO_CONTACT);
    // Boxes around the ball in all eight compass positions. The diagonals have
    // equal components and so check how ties are broken.
    add_row(make_pair(0, 0, 64, 0, 40, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, 40, 0, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, 0, -40, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, -40, 0, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, 40, 40, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, 40, -40, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, -40, -40, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, -40, 40, 64, 64), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 64, 63, 0, 0, 64), 1'b0, NO_CONTACT);
    // Contacts with offsets near the 16-bit limits in each direction.
    add_row(make_pair(-32768, -32768, 32767, -32767, -32768, 0, 32767), 1'b0, NO_CONTACT);
    add_row(make_pair(-32768, -32768, 32767, -2, -32768, 0, 32767), 1'b0, NO_CONTACT);
    add_row(make_pair(-32768, -32768, 32767, -32768, -32767, 32767, 0), 1'b0, NO_CONTACT);
    add_row(make_pair(-32768, -32768, 32767, -32768, -2, 32767, 0), 1'b0, NO_CONTACT);
    // The smallest ball, inside a box and then just beside a point box.
    add_row(make_pair(5, 5, 1, 0, 0, 20, 20), 1'b0, NO_CONTACT);
    add_row(make_pair(0, 0, 1, 0, 0, 0, 0), 1'b0, NO_CONTACT);

    // Reset is held from the start and released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      want = directed_rows[i].known ? directed_rows[i].want
                                    : predict_contact(directed_rows[i].pair);
      offer_pair(directed_rows[i].pair, want);
      pace_sender();
    end

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      rand_pair = random_pair();
      offer_pair(rand_pair, predict_contact(rand_pair));
      pace_sender();
    end
    req_ch.valid <= 1'b0;

    // Wait for the last results to drain, then a few more cycles for strays.
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pairs (%0d from the directed table), got %0d results, %0d contacts.",
             accepted_count, directed_rows.size(), results_seen, contact_count);
    $display("Hits: up %0d, right %0d, down %0d, left %0d, none %0d; req stalled %0d cycles.",
             dir_seen[DIR_UP] - (results_seen - contact_count), dir_seen[DIR_RIGHT],
             dir_seen[DIR_DOWN], dir_seen[DIR_LEFT], dir_seen[DIR_NONE], input_held_cycles);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
